@@ sv/ps2mpt_pkg.sv @@
package ps2mpt_pkg;

	// Cursor coordinate width
	localparam int COORD_BITS = 12;
	// Screen size register width
	localparam int SIZE_W = 13;
	// Signed step into the clamp unit: covers -256..256
	localparam int STEP_W = 10;
	// Working width of the move-and-clamp arithmetic
	localparam int CMP_W = ((COORD_BITS > SIZE_W) ? COORD_BITS : SIZE_W) + 2;

	// Configuration port
	localparam int ADDR_W = 3;
	localparam int DATA_W = 32;

	typedef enum logic [0:0] {
		REG_SCREEN_WIDTH  = 1'b0,
		REG_SCREEN_HEIGHT = 1'b1
	} reg_idx_t;

	localparam logic [SIZE_W-1:0] WIDTH_RST  = SIZE_W'(800);
	localparam logic [SIZE_W-1:0] HEIGHT_RST = SIZE_W'(600);
	localparam logic [COORD_BITS-1:0] CURSOR_RST = COORD_BITS'(50);

	typedef logic [COORD_BITS-1:0] coord_t;
	typedef logic [SIZE_W-1:0] size_t;
	typedef logic signed [STEP_W-1:0] step_t;

endpackage

@@ sv/ps2mpt_clamp.sv @@
module ps2mpt_clamp (
	input  ps2mpt_pkg::coord_t pos,
	input  ps2mpt_pkg::step_t  step,
	input  ps2mpt_pkg::size_t  size,
	output ps2mpt_pkg::coord_t result
);
	import ps2mpt_pkg::*;

	localparam logic signed [CMP_W-1:0] CMAX = CMP_W'((1 << COORD_BITS) - 1);

	logic signed [CMP_W-1:0] sum;
	logic signed [CMP_W-1:0] lim_raw;
	logic signed [CMP_W-1:0] lim;

	// Upper limit: size minus one, zero for a zero size, capped at coordinate range
	always_comb begin
		lim_raw = (size == '0) ? '0 : $signed(CMP_W'(size - SIZE_W'(1)));
		lim     = (lim_raw > CMAX) ? CMAX : lim_raw;
	end

	// Move and clamp to [0, lim]
	always_comb begin
		sum = $signed(CMP_W'(pos)) + CMP_W'(step);
		if (sum < 0) begin
			result = '0;
		end else if (sum > lim) begin
			result = lim[COORD_BITS-1:0];
		end else begin
			result = sum[COORD_BITS-1:0];
		end
	end

endmodule

@@ sv/ps2_mouse_packet_tracker_core.sv @@
// Channel   Handshake                   Payload
// in        in_valid / in_ready         data_byte
// out       out_valid / out_ready       pos_x, pos_y, delta_x, delta_y, button_bits
// config    APB psel/penable/pready     paddr, pwdata, prdata
//
// One byte is taken per cycle while in_ready is high; the third byte of a
// packet produces a result in the output register in the next cycle. Cursor
// move and clamp is one add and compare per axis ahead of that register.
// Reset clears the byte counter, the output valid, the cursor (50, 50) and the
// screen size registers (800 x 600).
// A held result stalls only a third byte; header and X bytes are still taken.
module ps2_mouse_packet_tracker_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [7:0]                    data_byte,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [ps2mpt_pkg::COORD_BITS-1:0] pos_x,
	output logic [ps2mpt_pkg::COORD_BITS-1:0] pos_y,
	output logic signed [8:0]             delta_x,
	output logic signed [8:0]             delta_y,
	output logic [3:0]                    button_bits,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [ps2mpt_pkg::ADDR_W-1:0] paddr,
	input  logic [ps2mpt_pkg::DATA_W-1:0] pwdata,
	output logic [ps2mpt_pkg::DATA_W-1:0] prdata,
	output logic                          pready
);
	import ps2mpt_pkg::*;

	logic [1:0]      byte_cnt_q;
	logic [7:0]      header_q;
	logic [7:0]      x_byte_q;
	coord_t          cursor_x_q;
	coord_t          cursor_y_q;
	size_t           width_q;
	size_t           height_q;

	logic            out_valid_q;
	coord_t          pos_x_q;
	coord_t          pos_y_q;
	logic signed [8:0] delta_x_q;
	logic signed [8:0] delta_y_q;
	logic [3:0]      buttons_q;

	logic            in_xfer;
	logic            last_byte;
	logic            pkt_done;
	logic            cfg_wr;
	reg_idx_t        reg_idx;
	logic signed [8:0] dx;
	logic signed [8:0] dy;
	step_t           step_x;
	step_t           step_y;
	logic [3:0]      buttons;
	coord_t          next_x;
	coord_t          next_y;

	// Handshake
	assign last_byte = (byte_cnt_q == 2'd2);
	assign in_ready  = !last_byte || !out_valid_q || out_ready;
	assign in_xfer   = in_valid && in_ready;
	assign pkt_done  = in_xfer && last_byte;

	// Packet decode: 9-bit deltas from header sign bits, button remap
	assign dx      = $signed({header_q[4], x_byte_q});
	assign dy      = $signed({header_q[5], data_byte});
	assign step_x  = STEP_W'(dx);
	assign step_y  = -STEP_W'(dy);
	assign buttons = {header_q[2], 1'b0, header_q[1], header_q[0]};

	ps2mpt_clamp u_clamp_x (
		.pos    (cursor_x_q),
		.step   (step_x),
		.size   (width_q),
		.result (next_x)
	);

	ps2mpt_clamp u_clamp_y (
		.pos    (cursor_y_q),
		.step   (step_y),
		.size   (height_q),
		.result (next_y)
	);

	// Byte counter and cursor
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_cnt_q <= '0;
			cursor_x_q <= CURSOR_RST;
			cursor_y_q <= CURSOR_RST;
		end else if (in_xfer) begin
			byte_cnt_q <= last_byte ? 2'd0 : byte_cnt_q + 2'd1;
			if (last_byte) begin
				cursor_x_q <= next_x;
				cursor_y_q <= next_y;
			end
		end
	end

	// Stored header and X bytes
	always_ff @(posedge clk) begin
		if (in_xfer && byte_cnt_q == 2'd0) begin
			header_q <= data_byte;
		end
		if (in_xfer && byte_cnt_q == 2'd1) begin
			x_byte_q <= data_byte;
		end
	end

	// Output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pkt_done) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (pkt_done) begin
			pos_x_q   <= next_x;
			pos_y_q   <= next_y;
			delta_x_q <= dx;
			delta_y_q <= dy;
			buttons_q <= buttons;
		end
	end

	assign out_valid   = out_valid_q;
	assign pos_x       = pos_x_q;
	assign pos_y       = pos_y_q;
	assign delta_x     = delta_x_q;
	assign delta_y     = delta_y_q;
	assign button_bits = buttons_q;

	// Configuration registers
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign reg_idx = reg_idx_t'(paddr[2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RST;
			height_q <= HEIGHT_RST;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_SCREEN_WIDTH:  width_q  <= pwdata[SIZE_W-1:0];
				REG_SCREEN_HEIGHT: height_q <= pwdata[SIZE_W-1:0];
				default: ;
			endcase
		end
	end

	// Register read
	always_comb begin
		unique case (reg_idx)
			REG_SCREEN_WIDTH:  prdata = DATA_W'(width_q);
			REG_SCREEN_HEIGHT: prdata = DATA_W'(height_q);
			default:           prdata = '0;
		endcase
	end

	// A completed packet always leaves a result behind
	a_pkt_result: assert property (@(posedge clk) disable iff (!arst_n)
		pkt_done |=> out_valid_q)
		else $error("completed packet left no result");

	// Cursor moves only on a completed packet
	a_cursor_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!pkt_done |=> ($stable(cursor_x_q) && $stable(cursor_y_q)))
		else $error("cursor moved without a packet");

	// A taken result with no new packet drains the output register
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_ready && !pkt_done) |=> !out_valid_q)
		else $error("result repeated");

	// Byte counter never reaches three
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		byte_cnt_q != 2'd3)
		else $error("byte counter out of range");

	// Output pos matches cursor after a packet
	a_pos_track: assert property (@(posedge clk) disable iff (!arst_n)
		pkt_done |=> (pos_x_q == cursor_x_q && pos_y_q == cursor_y_q))
		else $error("reported position differs from cursor");

endmodule
